[rtl/core/fcca_pkg.sv]
// Shared types and constants for the cluster chain allocator.
package fcca_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int POS_W       = ADDR_W + 1;
  localparam int LINK_W      = 28;
  localparam int COUNT_W     = 13;
  localparam int BYTES_W     = 32;
  localparam int CSIZE_W     = 16;

  localparam logic [LINK_W-1:0]  END_MARK    = 28'hFFFFFF8;
  localparam logic [LINK_W-1:0]  FIRST_DATA  = 28'd2;
  localparam logic [LINK_W-1:0]  TABLE_LIMIT = LINK_W'(TABLE_DEPTH);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [CSIZE_W-1:0] CSIZE_RESET = 16'd4096;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_WRITE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_BADARG = 2'd2,
    STATUS_BROKEN = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_ARD,
    ST_ACHK,
    ST_ALINK,
    ST_FRD,
    ST_FCHK,
    ST_RRD,
    ST_DONE
  } fsm_t;

  typedef struct packed {
    func_t               func;
    logic [BYTES_W-1:0]  byte_count;
    logic [LINK_W-1:0]   cluster;
    logic [LINK_W-1:0]   entry_value;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [LINK_W-1:0]   cluster_out;
    logic [COUNT_W-1:0]  freed_count;
  } rsp_t;

endpackage

[rtl/core/fcca_ram.sv]
// Generic simple dual-port RAM with registered read.
module fcca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/fcca_div.sv]
// Bit-serial divider that returns the rounded-up cluster count for a byte count.
module fcca_div
  import fcca_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [BYTES_W-1:0] dividend,
  input  logic [CSIZE_W-1:0] divisor,
  output logic               done,
  output logic [BYTES_W-1:0] need
);

  localparam int CNT_W = $clog2(BYTES_W);

  logic               busy;
  logic               fin;
  logic [CNT_W-1:0]   cnt;
  logic [BYTES_W-1:0] dq;
  logic [CSIZE_W-1:0] rem;
  logic [CSIZE_W-1:0] dvs;
  logic [CSIZE_W:0]   shifted;
  logic               qbit;
  logic [CSIZE_W-1:0] rem_next;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem, dq[BYTES_W-1]};
    qbit    = (shifted >= {1'b0, dvs});
    if (qbit) begin
      rem_next = CSIZE_W'(shifted - {1'b0, dvs});
    end else begin
      rem_next = shifted[CSIZE_W-1:0];
    end
  end

  // Control: run one bit per cycle, then round up in a final step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        fin  <= 1'b0;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(BYTES_W - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: quotient shifts in as the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= (divisor == '0) ? CSIZE_W'(1) : divisor;
    end else if (busy) begin
      dq  <= {dq[BYTES_W-2:0], qbit};
      rem <= rem_next;
    end else if (fin) begin
      need <= dq + BYTES_W'(rem != '0);
    end
  end

endmodule

[rtl/core/fat_cluster_chain_allocator.sv]
// Top level of the FAT-style cluster chain allocator.
//
// Requests arrive on req (req_valid/req_stall) and each gives exactly one
// response on rsp (rsp_valid/rsp_stall). A transfer happens on a rising edge
// with valid high and stall low. The link table lives in one RAM of
// TABLE_DEPTH 28-bit entries with a registered read. After reset the block
// sweeps the table to zero, one entry per cycle, holding req_stall high;
// cluster size writes on cfg (cfg_valid/cfg_ready, always ready) are taken
// at any time. A write request writes its entry and a read request reads it;
// a free request reads and clears each link of the chain in turn; an allocate
// request runs the bit-serial divide, then scans the table entry by entry,
// marks each free cluster found as the new tail and links the previous one to it.
// One request is worked at a time. The response sits in an output register;
// while rsp_stall holds it, a finished next request waits in its final state.
module fat_cluster_chain_allocator
  import fcca_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_t               rsp,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CSIZE_W-1:0] cfg_data
);

  fsm_t               state, state_next;
  logic [ADDR_W-1:0]  clr_addr, clr_addr_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic [ADDR_W-1:0]  prev, prev_next;
  logic               have_prev, have_prev_next;
  logic [ADDR_W-1:0]  first, first_next;
  logic [BYTES_W-1:0] need, need_next;
  logic [ADDR_W-1:0]  cur, cur_next;
  logic [COUNT_W-1:0] count, count_next;
  status_t            res_status, res_status_next;
  logic [LINK_W-1:0]  res_cluster, res_cluster_next;
  logic [CSIZE_W-1:0] cluster_bytes;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [LINK_W-1:0]  wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [LINK_W-1:0]  rd_data;
  logic               div_start;
  logic               div_done;
  logic [BYTES_W-1:0] div_need;
  logic               advance;
  logic               slot_free;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign slot_free = !rsp_valid || !rsp_stall;

  fcca_ram #(
    .WIDTH (LINK_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fcca_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req.byte_count),
    .divisor  (cluster_bytes),
    .done     (div_done),
    .need     (div_need)
  );

  // Cluster size register
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_bytes <= CSIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cluster_bytes <= cfg_data;
    end
  end

  // State and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      have_prev <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      have_prev <= have_prev_next;
    end
  end

  always_ff @(posedge clk) begin
    pos         <= pos_next;
    prev        <= prev_next;
    first       <= first_next;
    need        <= need_next;
    cur         <= cur_next;
    count       <= count_next;
    res_status  <= res_status_next;
    res_cluster <= res_cluster_next;
  end

  // Response register: load when the slot is free, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && slot_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && slot_free) begin
      rsp.status      <= res_status;
      rsp.cluster_out <= res_cluster;
      rsp.freed_count <= count;
    end
  end

  // Next state, table accesses and result fields
  always_comb begin
    state_next       = state;
    clr_addr_next    = clr_addr;
    pos_next         = pos;
    prev_next        = prev;
    have_prev_next   = have_prev;
    first_next       = first;
    need_next        = need;
    cur_next         = cur;
    count_next       = count;
    res_status_next  = res_status;
    res_cluster_next = res_cluster;
    wr_en            = 1'b0;
    wr_addr          = '0;
    wr_data          = '0;
    rd_en            = 1'b0;
    rd_addr          = '0;
    div_start        = 1'b0;
    advance          = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        wr_data       = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(TABLE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req_valid) begin
          res_status_next  = STATUS_OK;
          res_cluster_next = '0;
          count_next       = '0;
          unique case (req.func)
            FUNC_ALLOC: begin
              if (req.byte_count == '0) begin
                res_status_next = STATUS_BADARG;
                state_next      = ST_DONE;
              end else begin
                div_start      = 1'b1;
                pos_next       = POS_W'(FIRST_DATA);
                have_prev_next = 1'b0;
                first_next     = '0;
                state_next     = ST_DIV;
              end
            end
            FUNC_FREE: begin
              if (req.cluster >= END_MARK) begin
                state_next = ST_DONE;
              end else if (req.cluster < FIRST_DATA || req.cluster >= TABLE_LIMIT) begin
                res_status_next = STATUS_BADARG;
                state_next      = ST_DONE;
              end else begin
                cur_next   = req.cluster[ADDR_W-1:0];
                state_next = ST_FRD;
              end
            end
            FUNC_READ: begin
              if (req.cluster < TABLE_LIMIT) begin
                rd_en      = 1'b1;
                rd_addr    = req.cluster[ADDR_W-1:0];
                state_next = ST_RRD;
              end else begin
                res_status_next = STATUS_BADARG;
                state_next      = ST_DONE;
              end
            end
            FUNC_WRITE: begin
              if (req.cluster < TABLE_LIMIT) begin
                wr_en   = 1'b1;
                wr_addr = req.cluster[ADDR_W-1:0];
                wr_data = req.entry_value;
              end else begin
                res_status_next = STATUS_BADARG;
              end
              state_next = ST_DONE;
            end
          endcase
        end
      end

      ST_DIV: begin
        if (div_done) begin
          need_next  = div_need;
          state_next = ST_ARD;
        end
      end

      // Scan: read the candidate entry, or give up at the end of the table
      ST_ARD: begin
        if (pos == POS_W'(TABLE_DEPTH)) begin
          res_status_next  = STATUS_FULL;
          res_cluster_next = '0;
          state_next       = ST_DONE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = pos[ADDR_W-1:0];
          state_next = ST_ACHK;
        end
      end

      // Skip a used entry, or claim a free one as the new tail and then link the previous one to it
      ST_ACHK: begin
        if (rd_data != '0) begin
          pos_next   = pos + 1'b1;
          state_next = ST_ARD;
        end else begin
          wr_en   = 1'b1;
          wr_addr = pos[ADDR_W-1:0];
          wr_data = END_MARK;
          if (have_prev) begin
            state_next = ST_ALINK;
          end else begin
            advance = 1'b1;
          end
        end
      end

      ST_ALINK: begin
        wr_en   = 1'b1;
        wr_addr = prev;
        wr_data = LINK_W'(pos);
        advance = 1'b1;
      end

      ST_FRD: begin
        rd_en      = 1'b1;
        rd_addr    = cur;
        state_next = ST_FCHK;
      end

      // Clear the current link and follow it, stopping at an end mark or a bad link
      ST_FCHK: begin
        if (rd_data == '0) begin
          res_status_next = STATUS_BROKEN;
          state_next      = ST_DONE;
        end else begin
          wr_en   = 1'b1;
          wr_addr = cur;
          wr_data = '0;
          if (count != COUNT_MAX) begin
            count_next = count + 1'b1;
          end
          if (rd_data >= END_MARK) begin
            state_next = ST_DONE;
          end else if (rd_data < FIRST_DATA || rd_data >= TABLE_LIMIT) begin
            res_status_next = STATUS_BROKEN;
            state_next      = ST_DONE;
          end else begin
            cur_next   = rd_data[ADDR_W-1:0];
            state_next = ST_FRD;
          end
        end
      end

      ST_RRD: begin
        res_cluster_next = rd_data;
        state_next       = ST_DONE;
      end

      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
    endcase

    // Step the allocation past a newly linked cluster
    if (advance) begin
      prev_next      = pos[ADDR_W-1:0];
      have_prev_next = 1'b1;
      if (!have_prev) begin
        first_next = pos[ADDR_W-1:0];
      end
      pos_next  = pos + 1'b1;
      need_next = need - 1'b1;
      if (need == BYTES_W'(1)) begin
        res_status_next  = STATUS_OK;
        res_cluster_next = LINK_W'(have_prev ? first : pos[ADDR_W-1:0]);
        state_next       = ST_DONE;
      end else begin
        state_next = ST_ARD;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The RAM is never read and written at one address in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("table read and write collide on one address");

  // Allocation never marks a reserved cluster as a chain tail
  assert property (@(posedge clk) disable iff (rst)
    (wr_en && state == ST_ACHK) |-> (wr_addr >= ADDR_W'(FIRST_DATA)))
    else $error("allocation wrote a reserved cluster");

  // The freed count never goes back during a walk
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FCHK) |=> (count >= $past(count)))
    else $error("freed count decreased");

  // The divider only finishes while an allocation waits for it
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside an allocation");
`endif

endmodule
